// ===== hdl/hts_pkg.sv =====
// ----------------------------------------------------------------------------
// hts_pkg
// shared types and constants of the heading slew tracker: cordic angle table,
// datapath widths, queue entry layout and back end states
// ----------------------------------------------------------------------------
`default_nettype none

package hts_pkg;

    // cordic iteration count and the length of the arctangent table
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CORDIC_LAST  = ((CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN) - 1;
    localparam int ITER_W       = $clog2(ATAN_LEN);

    typedef logic [ITER_W-1:0] t_iter;

    // arctan(2^-i) as a 32-bit turn fraction
    localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam int ANGLE_W    = 16;
    localparam int COORD_W    = 16;
    localparam int DELTA_W    = COORD_W + 1;
    localparam int PRESCALE   = 24;
    // one sign bit for the negated delta, two bits of cordic gain headroom
    localparam int X_W        = DELTA_W + 1 + PRESCALE + 2;
    localparam int FACTOR_W   = 25;
    localparam int PROD_W     = ANGLE_W + FACTOR_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [FACTOR_W-1:0] ONE_Q24     = FACTOR_W'(1) << PRESCALE;
    localparam logic [PROD_W-1:0]   ROUND_Q24   = PROD_W'(1) << (PRESCALE - 1);
    localparam logic [31:0]         HALF_TURN_Z = 32'h80000000;
    localparam logic [31:0]         Z_ROUND     = 32'h00008000;
    localparam logic [ANGLE_W-1:0]  OFFSET_RESET = 16'hC000;

    // register map, indexed by paddr[2]
    localparam logic REG_TURN_RATE      = 1'b0;
    localparam logic REG_HEADING_OFFSET = 1'b1;

    typedef enum logic [1:0] {
        AIM_ANGLE,
        AIM_ZERO,
        AIM_POINT
    } t_aim_kind;

    typedef struct packed {
        t_aim_kind                  kind;
        logic                       snap;
        logic signed [DELTA_W-1:0]  dx;
        logic signed [DELTA_W-1:0]  dy;
        logic [ANGLE_W-1:0]         target;
        logic [FACTOR_W-1:0]        factor;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CORDIC,
        S_ROUND,
        S_DIFF,
        S_MUL,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/hts_front.sv =====
// ----------------------------------------------------------------------------
// hts_front
// classifies an incoming transaction and prepares its queue entry: point
// deltas, aim kind and the saturated slew factor
// ----------------------------------------------------------------------------
`default_nettype none

module hts_front (
    input  wire logic                                  i_action,
    input  wire logic signed [hts_pkg::COORD_W-1:0]    i_from_x,
    input  wire logic signed [hts_pkg::COORD_W-1:0]    i_from_y,
    input  wire logic signed [hts_pkg::COORD_W-1:0]    i_to_x,
    input  wire logic signed [hts_pkg::COORD_W-1:0]    i_to_y,
    input  wire logic [hts_pkg::ANGLE_W-1:0]           i_target_angle,
    input  wire logic [15:0]                           i_frame_time,
    input  wire logic [15:0]                           i_turn_rate,
    output hts_pkg::t_entry                            o_entry
);

    logic signed [hts_pkg::DELTA_W-1:0] w_dx;
    logic signed [hts_pkg::DELTA_W-1:0] w_dy;
    logic [31:0]                        w_rate_prod;

    assign w_dx = hts_pkg::DELTA_W'(i_to_x) - hts_pkg::DELTA_W'(i_from_x);
    assign w_dy = hts_pkg::DELTA_W'(i_to_y) - hts_pkg::DELTA_W'(i_from_y);

    // Q8.8 times Q0.16 gives Q8.24
    assign w_rate_prod = {16'b0, i_turn_rate} * {16'b0, i_frame_time};

    always_comb begin
        o_entry.dx     = w_dx;
        o_entry.dy     = w_dy;
        o_entry.target = i_target_angle;
        o_entry.snap   = (i_turn_rate == '0);
        if (w_rate_prod > 32'(hts_pkg::ONE_Q24)) begin
            o_entry.factor = hts_pkg::ONE_Q24;
        end else begin
            o_entry.factor = w_rate_prod[hts_pkg::FACTOR_W-1:0];
        end
        if (i_action) begin
            o_entry.kind = hts_pkg::AIM_ANGLE;
        end else if (w_dx == '0 && w_dy == '0) begin
            o_entry.kind = hts_pkg::AIM_ZERO;
        end else begin
            o_entry.kind = hts_pkg::AIM_POINT;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hts_queue.sv =====
// ----------------------------------------------------------------------------
// hts_queue
// short fifo of prepared entries between the front end and the back end
// ----------------------------------------------------------------------------
`default_nettype none

module hts_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire hts_pkg::t_entry  i_entry,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output hts_pkg::t_entry       o_entry
);

    localparam int PTR_W = (hts_pkg::QUEUE_DEPTH > 1) ? $clog2(hts_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(hts_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(hts_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(hts_pkg::QUEUE_DEPTH);

    hts_pkg::t_entry  r_mem [hts_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hts_back.sv =====
// ----------------------------------------------------------------------------
// hts_back
// executes one entry at a time: iterative cordic atan2, shortest difference,
// slew multiply and heading update, with a registered result stage
// ----------------------------------------------------------------------------
`default_nettype none

module hts_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_entry_valid,
    input  wire hts_pkg::t_entry               i_entry,
    output logic                               o_pop,
    input  wire logic [hts_pkg::ANGLE_W-1:0]   i_heading_offset,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [hts_pkg::ANGLE_W-1:0]        o_new_heading,
    output logic [hts_pkg::ANGLE_W-1:0]        o_aim_angle
);

    localparam int DW = hts_pkg::DELTA_W + 1;
    localparam logic signed [DW-1:0] HALF_POS = DW'(32768);
    localparam logic signed [DW-1:0] HALF_NEG = -DW'(32768);
    localparam logic signed [DW-1:0] FULL     = DW'(65536);

    hts_pkg::t_state r_state, n_state;

    logic signed [hts_pkg::X_W-1:0]      r_x, n_x;
    logic signed [hts_pkg::X_W-1:0]      r_y, n_y;
    logic [31:0]                         r_z, n_z;
    hts_pkg::t_iter                      r_iter, n_iter;
    logic [hts_pkg::ANGLE_W-1:0]         r_aim, n_aim;
    logic [hts_pkg::ANGLE_W-1:0]         r_mag, n_mag;
    logic                                r_neg, n_neg;
    logic                                r_snap, n_snap;
    logic [hts_pkg::FACTOR_W-1:0]        r_factor, n_factor;
    logic [hts_pkg::PROD_W-1:0]          r_prod, n_prod;
    logic [hts_pkg::ANGLE_W-1:0]         r_heading, n_heading;
    logic                                r_out_valid, n_out_valid;
    logic [hts_pkg::ANGLE_W-1:0]         r_out_heading, n_out_heading;
    logic [hts_pkg::ANGLE_W-1:0]         r_out_aim, n_out_aim;

    logic signed [DW-1:0]                w_ex, w_ey;
    logic signed [hts_pkg::X_W-1:0]      w_xs, w_ys;
    logic [31:0]                         w_zr;
    logic signed [DW-1:0]                w_d;
    logic [hts_pkg::PROD_W-1:0]          w_rounded;
    logic [hts_pkg::ANGLE_W-1:0]         w_step;
    logic                                w_out_free;

    assign o_valid       = r_out_valid;
    assign o_new_heading = r_out_heading;
    assign o_aim_angle   = r_out_aim;
    assign w_out_free    = !r_out_valid || i_ready;

    // shared shift-add unit, one cordic micro-rotation per cycle
    assign w_xs = r_x >>> r_iter;
    assign w_ys = r_y >>> r_iter;
    assign w_zr = r_z + hts_pkg::Z_ROUND;
    assign w_rounded = r_prod + hts_pkg::ROUND_Q24;
    assign w_step = w_rounded[hts_pkg::PRESCALE +: hts_pkg::ANGLE_W];

    always_comb begin
        // left half plane vectors are turned by a half turn first
        w_ex = DW'(i_entry.dx);
        w_ey = DW'(i_entry.dy);
        if (i_entry.dx < 0) begin
            w_ex = -w_ex;
            w_ey = -w_ey;
        end
    end

    always_comb begin
        w_d = DW'({2'b0, r_aim}) - DW'({2'b0, r_heading});
        if (w_d > HALF_POS) begin
            w_d = w_d - FULL;
        end else if (w_d < HALF_NEG) begin
            w_d = w_d + FULL;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_x           = r_x;
        n_y           = r_y;
        n_z           = r_z;
        n_iter        = r_iter;
        n_aim         = r_aim;
        n_mag         = r_mag;
        n_neg         = r_neg;
        n_snap        = r_snap;
        n_factor      = r_factor;
        n_prod        = r_prod;
        n_heading     = r_heading;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_heading = r_out_heading;
        n_out_aim     = r_out_aim;
        o_pop         = 1'b0;

        case (r_state)
            hts_pkg::S_IDLE: begin
                if (i_entry_valid) begin
                    o_pop    = 1'b1;
                    n_snap   = i_entry.snap;
                    n_factor = i_entry.factor;
                    n_iter   = '0;
                    n_x      = {{(hts_pkg::X_W - DW - hts_pkg::PRESCALE){w_ex[DW-1]}},
                                w_ex, {hts_pkg::PRESCALE{1'b0}}};
                    n_y      = {{(hts_pkg::X_W - DW - hts_pkg::PRESCALE){w_ey[DW-1]}},
                                w_ey, {hts_pkg::PRESCALE{1'b0}}};
                    n_z      = (i_entry.dx < 0) ? hts_pkg::HALF_TURN_Z : '0;
                    case (i_entry.kind)
                        hts_pkg::AIM_ANGLE: begin
                            n_aim   = i_entry.target;
                            n_state = hts_pkg::S_DIFF;
                        end
                        hts_pkg::AIM_ZERO: begin
                            // coincident points aim at direction zero
                            n_aim   = i_heading_offset;
                            n_state = hts_pkg::S_DIFF;
                        end
                        default: begin
                            n_state = hts_pkg::S_CORDIC;
                        end
                    endcase
                end
            end
            hts_pkg::S_CORDIC: begin
                if (!r_y[hts_pkg::X_W-1]) begin
                    n_x = r_x + w_ys;
                    n_y = r_y - w_xs;
                    n_z = r_z + hts_pkg::ATAN_TURNS[r_iter];
                end else begin
                    n_x = r_x - w_ys;
                    n_y = r_y + w_xs;
                    n_z = r_z - hts_pkg::ATAN_TURNS[r_iter];
                end
                n_iter = r_iter + 1'b1;
                if (r_iter == hts_pkg::t_iter'(hts_pkg::CORDIC_LAST)) begin
                    n_state = hts_pkg::S_ROUND;
                end
            end
            hts_pkg::S_ROUND: begin
                n_aim   = w_zr[31:16] + i_heading_offset;
                n_state = hts_pkg::S_DIFF;
            end
            hts_pkg::S_DIFF: begin
                n_neg   = w_d[DW-1];
                n_mag   = w_d[DW-1] ? hts_pkg::ANGLE_W'(-w_d) : hts_pkg::ANGLE_W'(w_d);
                n_state = hts_pkg::S_MUL;
            end
            hts_pkg::S_MUL: begin
                n_prod  = hts_pkg::PROD_W'(r_mag) * hts_pkg::PROD_W'(r_factor);
                n_state = hts_pkg::S_DONE;
            end
            hts_pkg::S_DONE: begin
                if (w_out_free) begin
                    if (r_snap) begin
                        n_heading = r_aim;
                    end else if (r_neg) begin
                        n_heading = r_heading - w_step;
                    end else begin
                        n_heading = r_heading + w_step;
                    end
                    n_out_valid   = 1'b1;
                    n_out_heading = n_heading;
                    n_out_aim     = r_aim;
                    n_state       = hts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hts_pkg::S_IDLE;
            r_heading   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_heading   <= n_heading;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x           <= n_x;
        r_y           <= n_y;
        r_z           <= n_z;
        r_iter        <= n_iter;
        r_aim         <= n_aim;
        r_mag         <= n_mag;
        r_neg         <= n_neg;
        r_snap        <= n_snap;
        r_factor      <= n_factor;
        r_prod        <= n_prod;
        r_out_heading <= n_out_heading;
        r_out_aim     <= n_out_aim;
    end

endmodule

`default_nettype wire

// ===== hdl/heading_slew_tracker.sv =====
// ----------------------------------------------------------------------------
// heading_slew_tracker
// turns a stored heading toward a target angle or point direction each
// transaction, with configurable turn rate and point direction offset
// ----------------------------------------------------------------------------
// The front end classifies each input transaction and queues it (two entries)
// so new transactions are taken while the back end works or while a result
// waits on the output. The back end handles one transaction at a time: an
// angle-mode or coincident-point transaction goes through the difference,
// multiply and done states to the output register, a point-mode transaction
// first through 16 cordic micro-rotations, run one per cycle on a single
// shift-add unit, and a rounding state. turn_rate (address 0,
// Q8.8 per second, zero snaps to target) and heading_offset (address 4,
// reset 0xC000) are read back on prdata and must be written only while idle.
`default_nettype none

module heading_slew_tracker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic                                  i_action,
    input  wire logic signed [hts_pkg::COORD_W-1:0]    i_from_x,
    input  wire logic signed [hts_pkg::COORD_W-1:0]    i_from_y,
    input  wire logic signed [hts_pkg::COORD_W-1:0]    i_to_x,
    input  wire logic signed [hts_pkg::COORD_W-1:0]    i_to_y,
    input  wire logic [hts_pkg::ANGLE_W-1:0]           i_target_angle,
    input  wire logic [15:0]                           i_frame_time,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic [hts_pkg::ANGLE_W-1:0]                o_new_heading,
    output logic [hts_pkg::ANGLE_W-1:0]                o_aim_angle,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [2:0]                            paddr,
    input  wire logic [31:0]                           pwdata,
    output logic [31:0]                                prdata,
    output logic                                       pready
);

    logic [15:0]                  r_turn_rate;
    logic [hts_pkg::ANGLE_W-1:0]  r_heading_offset;
    logic                         w_cfg_wr;
    logic                         w_push;
    logic                         w_full;
    logic                         w_q_valid;
    logic                         w_pop;
    hts_pkg::t_entry              w_front_entry;
    hts_pkg::t_entry              w_q_entry;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == hts_pkg::REG_HEADING_OFFSET) ?
                      {16'b0, r_heading_offset} : {16'b0, r_turn_rate};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_rate      <= '0;
            r_heading_offset <= hts_pkg::OFFSET_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == hts_pkg::REG_TURN_RATE) begin
                r_turn_rate <= pwdata[15:0];
            end else begin
                r_heading_offset <= pwdata[hts_pkg::ANGLE_W-1:0];
            end
        end
    end

    assign o_ready = !w_full;
    assign w_push  = i_valid && !w_full;

    hts_front u_front (
        .i_action       (i_action),
        .i_from_x       (i_from_x),
        .i_from_y       (i_from_y),
        .i_to_x         (i_to_x),
        .i_to_y         (i_to_y),
        .i_target_angle (i_target_angle),
        .i_frame_time   (i_frame_time),
        .i_turn_rate    (r_turn_rate),
        .o_entry        (w_front_entry)
    );

    hts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_front_entry),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_entry (w_q_entry)
    );

    hts_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_entry_valid    (w_q_valid),
        .i_entry          (w_q_entry),
        .o_pop            (w_pop),
        .i_heading_offset (r_heading_offset),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_new_heading    (o_new_heading),
        .o_aim_angle      (o_aim_angle)
    );

endmodule

`default_nettype wire

// ===== hdl/hts_checker.sv =====
// ----------------------------------------------------------------------------
// hts_checker
// port-level checks of the heading slew tracker, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module hts_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_valid,
    input wire logic         o_ready,
    input wire logic         o_valid,
    input wire logic         i_ready,
    input wire logic [15:0]  o_new_heading,
    input wire logic [15:0]  o_aim_angle,
    input wire logic         psel,
    input wire logic         penable,
    input wire logic         pwrite,
    input wire logic [2:0]   paddr,
    input wire logic [31:0]  pwdata,
    input wire logic [31:0]  prdata
);

    logic [2:0] r_inflight;
    logic       w_in_fire;
    logic       w_out_fire;

    assign w_in_fire  = i_valid && o_ready;
    assign w_out_fire = o_valid && i_ready;

    // transactions accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (w_in_fire && !w_out_fire) begin
            r_inflight <= r_inflight + 1'b1;
        end else if (w_out_fire && !w_in_fire) begin
            r_inflight <= r_inflight - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_new_heading) && $stable(o_aim_angle))
        else $error("result changed while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_inflight != 3'd0)
        else $error("result without an outstanding transaction");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight == 3'd4 |-> !o_ready)
        else $error("ready high with queue, back end and output all occupied");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && !paddr[2]) ##1 (psel && !pwrite && !paddr[2])
        |-> prdata[15:0] == $past(pwdata[15:0]))
        else $error("turn_rate readback mismatch");

endmodule

bind heading_slew_tracker hts_checker u_hts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_new_heading (o_new_heading),
    .o_aim_angle   (o_aim_angle),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);

`default_nettype wire
